>>> rtl/core/dart_pkg.sv
// shared types, codes and constants for the divider and reload timer
`default_nettype none

package dart_pkg;

    // item kinds
    localparam logic [1:0] KIND_CLOCKS = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_WRITE  = 2'd2;

    // register selects
    localparam logic [1:0] SEL_DIVIDER = 2'd0;
    localparam logic [1:0] SEL_COUNTER = 2'd1;
    localparam logic [1:0] SEL_RELOAD  = 2'd2;
    localparam logic [1:0] SEL_CONTROL = 2'd3;

    // control register bits
    localparam int CTRL_ENABLE_BIT = 2;
    localparam int CTRL_RATE_HI    = 1;
    localparam int CTRL_RATE_LO    = 0;

    // counter prescale: stays below the longest tick length, plus one 8-bit elapsed_clocks step
    localparam int CPRE_W = 11;

    // beat widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    typedef struct packed {
        logic start;   // input beat accepted this cycle
        logic tick;    // step the prescalers one tick
        logic load;    // move the result into the output register
    } dart_cmd_t;

    typedef struct packed {
        logic pending; // a divider or counter tick is still owed
    } dart_status_t;

    // counter tick length for control bits 1:0
    function automatic logic [CPRE_W-1:0] tick_len(input logic [1:0] rate);
        logic [CPRE_W-1:0] len;
        begin
            unique case (rate)
                2'd0:    len = CPRE_W'(1024);
                2'd1:    len = CPRE_W'(16);
                2'd2:    len = CPRE_W'(64);
                default: len = CPRE_W'(256);
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/dart_ctrl.sv
// controller state machine for the divider and reload timer
`default_nettype none

module dart_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output dart_pkg::dart_cmd_t        cmd,
    input  wire dart_pkg::dart_status_t status
);
    import dart_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd.start = s_tvalid && (state_reg == ST_IDLE);
        cmd.tick  = (state_reg == ST_RUN);
        cmd.load  = (state_reg == ST_RUN) && !status.pending && slot_free;
    end

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!status.pending && slot_free) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

>>> rtl/core/dart_datapath.sv
// timer registers, prescalers and result register of the divider and reload timer
`default_nettype none

module dart_datapath #(
    parameter int DIVIDER_PERIOD = 256
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [1:0]            kind,
    input  wire logic [7:0]            elapsed_clocks,
    input  wire logic [1:0]            reg_select,
    input  wire logic [7:0]            write_data,
    input  wire dart_pkg::dart_cmd_t   cmd,
    output dart_pkg::dart_status_t     status,
    output logic [7:0]                 read_data,
    output logic                       timer_irq
);
    import dart_pkg::*;

    // divider prescale stays below the period, plus one step of clocks
    localparam int DPRE_W = $clog2(DIVIDER_PERIOD + 256);
    localparam logic [DPRE_W-1:0] DIV_PERIOD = DPRE_W'(DIVIDER_PERIOD);

    logic [DPRE_W-1:0] dpre_reg;
    logic [7:0]        div_reg;
    logic [CPRE_W-1:0] cpre_reg;
    logic [7:0]        cnt_reg;
    logic [7:0]        reload_reg;
    logic [7:0]        ctrl_reg;
    logic [7:0]        rd_reg;
    logic              irq_reg;
    logic              clk_beat_reg;
    logic [7:0]        read_data_reg;
    logic              timer_irq_reg;

    logic [CPRE_W-1:0] len;
    logic              enable;
    logic              div_due;
    logic              cnt_due;
    logic [7:0]        rd_mux;

    assign len     = tick_len(ctrl_reg[CTRL_RATE_HI:CTRL_RATE_LO]);
    assign enable  = ctrl_reg[CTRL_ENABLE_BIT];
    assign div_due = (dpre_reg >= DIV_PERIOD);
    // owed counter ticks are only spent by a clocks beat
    assign cnt_due = enable && clk_beat_reg && (cpre_reg >= len);
    assign status.pending = div_due || cnt_due;

    always_comb begin
        unique case (reg_select)
            SEL_DIVIDER: rd_mux = div_reg;
            SEL_COUNTER: rd_mux = cnt_reg;
            SEL_RELOAD:  rd_mux = reload_reg;
            default:     rd_mux = ctrl_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dpre_reg     <= '0;
            div_reg      <= 8'd1;
            cpre_reg     <= '0;
            cnt_reg      <= '0;
            reload_reg   <= '0;
            ctrl_reg     <= '0;
            rd_reg       <= '0;
            irq_reg      <= 1'b0;
            clk_beat_reg <= 1'b0;
        end else if (cmd.start) begin
            rd_reg       <= (kind == KIND_READ) ? rd_mux : 8'd0;
            irq_reg      <= 1'b0;
            clk_beat_reg <= (kind == KIND_CLOCKS);
            case (kind)
                KIND_CLOCKS: begin
                    dpre_reg <= dpre_reg + {{(DPRE_W-8){1'b0}}, elapsed_clocks};
                    if (enable) begin
                        cpre_reg <= cpre_reg + {{(CPRE_W-8){1'b0}}, elapsed_clocks};
                    end
                end
                KIND_WRITE: begin
                    unique case (reg_select)
                        SEL_DIVIDER: begin
                            div_reg  <= '0;
                            dpre_reg <= '0;
                        end
                        SEL_COUNTER: begin
                            cnt_reg  <= '0;
                            cpre_reg <= '0;
                        end
                        SEL_RELOAD:  reload_reg <= write_data;
                        default:     ctrl_reg   <= write_data;
                    endcase
                end
                default: ;
            endcase
        end else if (cmd.tick) begin
            // one divider tick and one counter tick per cycle
            if (div_due) begin
                dpre_reg <= dpre_reg - DIV_PERIOD;
                div_reg  <= div_reg + 8'd1;
            end
            if (cnt_due) begin
                cpre_reg <= cpre_reg - len;
                if (cnt_reg == 8'hFF) begin
                    cnt_reg <= reload_reg;
                    irq_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 8'd1;
                end
            end
        end
    end

    // output register, no reset needed on payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            read_data_reg <= rd_reg;
            timer_irq_reg <= irq_reg;
        end
    end

    assign read_data = read_data_reg;
    assign timer_irq = timer_irq_reg;

endmodule

`default_nettype wire

>>> rtl/core/divider_and_reload_timer.sv
// a beat is accepted in the idle state; its result is loaded in the run state once no
// tick is owed and the output register is free; a clocks beat owing n ticks (max of
// divider and counter ticks) stays in run as the step loop retires one divider tick
// and one counter tick per cycle; the input reopens once the result is registered
// a finished result waits in the output register while the next beat is taken
// reset: synchronous active-low aresetn; divider reads 1, other timer registers 0
`default_nettype none

module divider_and_reload_timer #(
    parameter int DIVIDER_PERIOD = 256
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input beat
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [1:0] kind, [9:2] elapsed_clocks, [11:10] reg_select, [19:12] write_data,
    // [23:20] zero
    input  wire logic [dart_pkg::S_TDATA_W-1:0]   s_tdata,
    // result beat
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [7:0] read_data, [8] timer_irq, [15:9] zero
    output logic [dart_pkg::M_TDATA_W-1:0]        m_tdata
);
    import dart_pkg::*;

    dart_cmd_t    cmd;
    dart_status_t status;

    // unpacked input fields
    logic [1:0] kind;
    logic [7:0] elapsed_clocks;
    logic [1:0] reg_select;
    logic [7:0] write_data;

    logic [7:0] read_data;
    logic       timer_irq;

    assign kind           = s_tdata[1:0];
    assign elapsed_clocks = s_tdata[9:2];
    assign reg_select     = s_tdata[11:10];
    assign write_data     = s_tdata[19:12];

    // sequencer: idle until a beat arrives, then steps ticks and hands off the result
    dart_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // timer registers, prescalers and the output register
    dart_datapath #(
        .DIVIDER_PERIOD (DIVIDER_PERIOD)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .kind           (kind),
        .elapsed_clocks (elapsed_clocks),
        .reg_select     (reg_select),
        .write_data     (write_data),
        .cmd            (cmd),
        .status         (status),
        .read_data      (read_data),
        .timer_irq      (timer_irq)
    );

    // pack the result beat, upper bits zero
    assign m_tdata = {{(M_TDATA_W-9){1'b0}}, timer_irq, read_data};

endmodule

`default_nettype wire

>>> rtl/core/dart_checker.sv
// port-level checks for the divider and reload timer, bound to the top level
`default_nettype none

module dart_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [23:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // result beat holds while stalled
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one beat in work at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input beat accepted while busy");

    // an interrupt comes only from a clocks beat, which reads zero
    a_irq_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tdata[7:0] == 8'd0)
        else $error("interrupt reported with read data");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:9] == 7'd0)
        else $error("result padding not zero");

endmodule

bind divider_and_reload_timer dart_checker u_dart_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
